FILE: hdl/text_console_glyph_renderer_defines.svh
// ----------------------------------------------------------------------------
// Text console glyph renderer: assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH

// Same-cycle implication.
`define TCGR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TCGR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Transfer types, command and register codes, job classes and status groups.
// ----------------------------------------------------------------------------
package tcgr_pkg;

	localparam int GLYPH_SIZE = 8;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;

	localparam logic [1:0] CMD_PRINT  = 2'd0;
	localparam logic [1:0] CMD_LOAD   = 2'd1;
	localparam logic [1:0] CMD_SETPOS = 2'd2;

	localparam logic [7:0] CHAR_TAB     = 8'd9;
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_FIRST   = 8'd32;

	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] REG_FG_COLOR     = 3'd2;
	localparam logic [2:0] REG_BACK_COLOR   = 3'd3;
	localparam logic [2:0] REG_OPAQUE       = 3'd4;
	localparam logic [2:0] REG_MARGIN_LEFT  = 3'd5;
	localparam logic [2:0] REG_MARGIN_TOP   = 3'd6;
	localparam logic [2:0] REG_LINE_PITCH   = 3'd7;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  char_code;
		logic [6:0]  glyph_index;
		logic [63:0] glyph_bits;
		logic [9:0]  pos_x;
		logic [9:0]  pos_y;
	} in_item_t;

	typedef struct packed {
		logic [19:0] pixel_address;
		logic [15:0] color_0;
		logic [15:0] color_1;
		logic [15:0] color_2;
		logic [15:0] color_3;
		logic [15:0] color_4;
		logic [15:0] color_5;
		logic [15:0] color_6;
		logic [15:0] color_7;
		logic [7:0]  write_mask;
		logic        last_row;
	} out_item_t;

	typedef struct packed {
		logic [10:0] frame_width;
		logic [10:0] frame_height;
		logic [15:0] fg_color;
		logic [15:0] back_color;
		logic        opaque;
		logic [9:0]  margin_left;
		logic [9:0]  margin_top;
		logic [5:0]  line_pitch;
	} cfg_t;

	typedef enum logic [2:0] {
		KIND_GLYPH,
		KIND_TAB,
		KIND_NEWLINE,
		KIND_SKIP,
		KIND_LOAD,
		KIND_SETPOS
	} kind_t;

	// Slot is wide enough for any font size the block supports.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  slot;
		logic [63:0] bits;
		logic [9:0]  pos_x;
		logic [9:0]  pos_y;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EDGE,
		BK_MUL,
		BK_ROW
	} bk_state_t;

	typedef struct packed {
		logic idle;
		logic emit;
		logic last_emit;
	} bk_stat_t;

endpackage

FILE: hdl/tcgr_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding framebuffer geometry, colors and margins.
// ----------------------------------------------------------------------------
module tcgr_regs import tcgr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= 11'd320;
			cfg_q.frame_height <= 11'd240;
			cfg_q.fg_color     <= 16'hFFFF;
			cfg_q.back_color   <= 16'h0000;
			cfg_q.opaque       <= 1'b1;
			cfg_q.margin_left  <= 10'd8;
			cfg_q.margin_top   <= 10'd8;
			cfg_q.line_pitch   <= 6'd12;
		end else if (wr) begin
			case (idx)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[10:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[10:0];
				REG_FG_COLOR:     cfg_q.fg_color     <= pwdata[15:0];
				REG_BACK_COLOR:   cfg_q.back_color   <= pwdata[15:0];
				REG_OPAQUE:       cfg_q.opaque       <= pwdata[0];
				REG_MARGIN_LEFT:  cfg_q.margin_left  <= pwdata[9:0];
				REG_MARGIN_TOP:   cfg_q.margin_top   <= pwdata[9:0];
				REG_LINE_PITCH:   cfg_q.line_pitch   <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FRAME_WIDTH:  prdata = {21'd0, cfg_q.frame_width};
			REG_FRAME_HEIGHT: prdata = {21'd0, cfg_q.frame_height};
			REG_FG_COLOR:     prdata = {16'd0, cfg_q.fg_color};
			REG_BACK_COLOR:   prdata = {16'd0, cfg_q.back_color};
			REG_OPAQUE:       prdata = {31'd0, cfg_q.opaque};
			REG_MARGIN_LEFT:  prdata = {22'd0, cfg_q.margin_left};
			REG_MARGIN_TOP:   prdata = {22'd0, cfg_q.margin_top};
			REG_LINE_PITCH:   prdata = {26'd0, cfg_q.line_pitch};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

FILE: hdl/tcgr_front.sv
// ----------------------------------------------------------------------------
// Command front end
// Accepts commands, classifies them into jobs and queues them for the back end.
// ----------------------------------------------------------------------------
module tcgr_front import tcgr_pkg::*; #(
	parameter int FONT_GLYPHS = 96
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  in_item_t cmd_item,
	output logic     job_valid,
	output job_t     job,
	input  logic     job_pop
);

	localparam logic [8:0] GLYPHS9 = 9'(FONT_GLYPHS);

	job_t            queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	job_t       cls;
	logic       keep;
	logic       push;
	logic       accept;
	logic [8:0] code_off;

	assign cmd_stall = (count_q == (QPTR_W+1)'(QDEPTH));
	assign accept    = cmd_valid && !cmd_stall;
	assign push      = accept && keep;
	assign job_valid = (count_q != '0);
	assign job       = queue_q[rd_ptr_q];

	assign code_off = {1'b0, cmd_item.char_code} - {1'b0, CHAR_FIRST};

	// Classify: drop unused commands and loads past the font end.
	always_comb begin
		cls.kind  = KIND_SKIP;
		cls.slot  = 8'd0;
		cls.bits  = cmd_item.glyph_bits;
		cls.pos_x = cmd_item.pos_x;
		cls.pos_y = cmd_item.pos_y;
		keep      = 1'b1;
		case (cmd_item.cmd)
			CMD_PRINT: begin
				if (cmd_item.char_code == CHAR_NEWLINE) begin
					cls.kind = KIND_NEWLINE;
				end else if (cmd_item.char_code == CHAR_TAB) begin
					cls.kind = KIND_TAB;
				end else if (cmd_item.char_code >= CHAR_FIRST && code_off < GLYPHS9) begin
					cls.kind = KIND_GLYPH;
					cls.slot = code_off[7:0];
				end else begin
					cls.kind = KIND_SKIP;
				end
			end
			CMD_LOAD: begin
				cls.kind = KIND_LOAD;
				cls.slot = {1'b0, cmd_item.glyph_index};
				keep     = ({2'b00, cmd_item.glyph_index} < GLYPHS9);
			end
			CMD_SETPOS: begin
				cls.kind = KIND_SETPOS;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (job_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !job_pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (!push && job_pop)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= cls;
	end

endmodule

FILE: hdl/tcgr_back.sv
// ----------------------------------------------------------------------------
// Render back end
// Runs queued jobs: cursor edge checks, font store, row writes to the output.
// ----------------------------------------------------------------------------
module tcgr_back import tcgr_pkg::*; #(
	parameter int FONT_GLYPHS   = 96,
	parameter int MARGIN_RIGHT  = 8,
	parameter int MARGIN_BOTTOM = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      job_valid,
	input  job_t      job,
	output logic      job_pop,
	output logic      pix_valid,
	input  logic      pix_stall,
	output out_item_t pix_item,
	output bk_stat_t  stat
);

	localparam int SLOT_W = (FONT_GLYPHS > 1) ? $clog2(FONT_GLYPHS) : 1;
	localparam logic [11:0] RIGHT_OFF  = 12'(MARGIN_RIGHT + GLYPH_SIZE);
	localparam logic [11:0] BOTTOM_OFF = 12'(MARGIN_BOTTOM + GLYPH_SIZE);

	logic [63:0] font_mem [FONT_GLYPHS];

	bk_state_t   state_q, state_d;
	logic [10:0] cur_x_q, cur_y_q;
	logic        tab_q;
	logic [1:0]  tab_cnt_q;
	logic [2:0]  row_q;
	logic [63:0] glyph_q;
	logic [19:0] prod_q;
	logic [19:0] acc_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic              out_free, emit, last_glyph_row, more_tab, last_emit;
	logic              pop, edge_en, rd_en, is_draw;
	logic [SLOT_W-1:0] rd_slot;
	logic [10:0]       x_a, y_a, y_b, x_e, y_e;
	logic              wrap_r, wrap_b;
	logic [19:0]       row_addr;
	logic [7:0]        row_bits;
	logic [21:0]       prod;
	out_item_t         row_item;

	function automatic logic [15:0] pick(input logic fg, input cfg_t c);
		if (fg)
			pick = c.fg_color;
		else if (c.opaque)
			pick = c.back_color;
		else
			pick = 16'd0;
	endfunction

	assign out_free  = !out_valid_q || !pix_stall;
	assign pix_valid = out_valid_q;
	assign pix_item  = out_q;
	assign job_pop   = pop;

	// Control and datapath decode. A tab checks the edges once for itself and
	// then again in the edge state before each of its spaces.
	always_comb begin
		pop     = (state_q == BK_IDLE) && job_valid;
		is_draw = (job.kind == KIND_GLYPH) || (job.kind == KIND_TAB);
		edge_en = (pop && (is_draw || job.kind == KIND_NEWLINE || job.kind == KIND_SKIP))
			|| (state_q == BK_EDGE);
		rd_en   = (pop && job.kind == KIND_GLYPH) || (state_q == BK_EDGE);
		rd_slot = (state_q == BK_EDGE) ? '0 : job.slot[SLOT_W-1:0];

		// Right edge, then bottom edge on the wrapped y.
		wrap_r = ({1'b0, cur_x_q} + RIGHT_OFF) > {1'b0, cfg.frame_width};
		x_a    = wrap_r ? {1'b0, cfg.margin_left} : cur_x_q;
		y_a    = wrap_r ? (cur_y_q + {5'd0, cfg.line_pitch}) : cur_y_q;
		wrap_b = ({1'b0, y_a} + BOTTOM_OFF) >= {1'b0, cfg.frame_height};
		y_b    = wrap_b ? {1'b0, cfg.margin_top} : y_a;
		if (pop && job.kind == KIND_NEWLINE) begin
			x_e = {1'b0, cfg.margin_left};
			y_e = y_b + {5'd0, cfg.line_pitch};
		end else begin
			x_e = x_a;
			y_e = y_b;
		end

		emit           = (state_q == BK_ROW) && out_free;
		last_glyph_row = (row_q == 3'd7);
		more_tab       = tab_q && (tab_cnt_q != 2'd3);
		last_emit      = emit && last_glyph_row && !more_tab;

		prod     = cur_y_q * cfg.frame_width;
		row_addr = (row_q == 3'd0) ? ({9'd0, cur_x_q} + prod_q) : acc_q;
		row_bits = glyph_q[{row_q, 3'b000} +: 8];

		row_item.pixel_address = row_addr;
		row_item.color_0       = pick(row_bits[0], cfg);
		row_item.color_1       = pick(row_bits[1], cfg);
		row_item.color_2       = pick(row_bits[2], cfg);
		row_item.color_3       = pick(row_bits[3], cfg);
		row_item.color_4       = pick(row_bits[4], cfg);
		row_item.color_5       = pick(row_bits[5], cfg);
		row_item.color_6       = pick(row_bits[6], cfg);
		row_item.color_7       = pick(row_bits[7], cfg);
		row_item.write_mask    = cfg.opaque ? 8'hFF : row_bits;
		row_item.last_row      = last_glyph_row && !more_tab;

		stat.idle      = (state_q == BK_IDLE);
		stat.emit      = emit;
		stat.last_emit = last_emit;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (pop && job.kind == KIND_GLYPH)
					state_d = BK_MUL;
				else if (pop && job.kind == KIND_TAB)
					state_d = BK_EDGE;
			end
			BK_EDGE: state_d = BK_MUL;
			BK_MUL:  state_d = BK_ROW;
			BK_ROW: begin
				if (emit && last_glyph_row)
					state_d = more_tab ? BK_EDGE : BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cur_x_q     <= 11'd8;
			cur_y_q     <= 11'd8;
			tab_q       <= 1'b0;
			tab_cnt_q   <= 2'd0;
			row_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (edge_en) begin
				cur_x_q <= x_e;
				cur_y_q <= y_e;
			end else if (pop && job.kind == KIND_SETPOS) begin
				cur_x_q <= {1'b0, job.pos_x};
				cur_y_q <= {1'b0, job.pos_y};
			end else if (emit && last_glyph_row) begin
				cur_x_q <= cur_x_q + 11'(GLYPH_SIZE);
			end
			if (pop) begin
				tab_q     <= (job.kind == KIND_TAB);
				tab_cnt_q <= 2'd0;
			end else if (emit && last_glyph_row && more_tab) begin
				tab_cnt_q <= tab_cnt_q + 2'd1;
			end
			if (state_q == BK_MUL)
				row_q <= 3'd0;
			else if (emit)
				row_q <= row_q + 3'd1;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!pix_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Font store and row datapath
	always_ff @(posedge clk) begin
		if (pop && job.kind == KIND_LOAD)
			font_mem[job.slot[SLOT_W-1:0]] <= job.bits;
		if (rd_en)
			glyph_q <= font_mem[rd_slot];
		if (state_q == BK_MUL)
			prod_q <= prod[19:0];
		if (emit) begin
			acc_q <= row_addr + {9'd0, cfg.frame_width};
			out_q <= row_item;
		end
	end

endmodule

FILE: hdl/text_console_glyph_renderer.sv
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Prints characters as 8x8 glyph row writes into a 16-bit framebuffer.
// ----------------------------------------------------------------------------
// Throughput: one command per cycle into a 4-entry queue unless cmd_stall is
//   high; the back end runs a glyph as an edge check and font read, a multiply,
//   then 8 row writes at one per cycle while the output is not stalled; a tab
//   as its own edge check and four spaces; newline, load, setpos, skip at pop.
// Path: the queue, the edge check and font read, the multiply, then the row
//   register (a tab adds its own edge check first). Reset: registers to
//   defaults, cursor to (8,8), queue and output empty; the font store holds nothing until loaded.
`include "text_console_glyph_renderer_defines.svh"

module text_console_glyph_renderer import tcgr_pkg::*; #(
	parameter int FONT_GLYPHS   = 96,
	parameter int MARGIN_RIGHT  = 8,
	parameter int MARGIN_BOTTOM = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  in_item_t    cmd_item,
	// row write channel
	output logic        pix_valid,
	input  logic        pix_stall,
	output out_item_t   pix_item,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t     cfg;
	job_t     job;
	logic     job_valid;
	logic     job_pop;
	bk_stat_t stat;

	// Register file: geometry, colors, margins.
	tcgr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Front end: take each transfer, classify it and queue the job. Unused
	// commands and loads past the font end are dropped here.
	tcgr_front #(
		.FONT_GLYPHS (FONT_GLYPHS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	// Back end: own the cursor and the font store, and run each job. Rows go
	// through an output register so the back end only holds when that register
	// is full and stalled.
	tcgr_back #(
		.FONT_GLYPHS   (FONT_GLYPHS),
		.MARGIN_RIGHT  (MARGIN_RIGHT),
		.MARGIN_BOTTOM (MARGIN_BOTTOM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_item  (pix_item),
		.stat      (stat)
	);

	// A new row never overwrites one that is still waiting.
	`TCGR_ASSERT_IMP(a_no_overwrite, clk, arst_n, stat.emit, !pix_valid || !pix_stall, "row write overwrote a pending transfer")
	// A row that is not the final one means the back end still has rows to go.
	`TCGR_ASSERT_IMP(a_rows_pending, clk, arst_n, pix_valid && !pix_item.last_row, !stat.idle, "back end idle with rows outstanding")
	// The final row of a command returns the back end to idle.
	`TCGR_ASSERT_NXT(a_last_idle, clk, arst_n, stat.last_emit, stat.idle, "back end busy after final row")

endmodule
